### hdl/sasd_pkg.sv
// ----------------------------------------------------------------------------
// sasd_pkg: shared types and constants
// Sizes, opcodes, status codes and the structs passed between the cells,
// the match scanner and the top level of the shift array.
// ----------------------------------------------------------------------------
`default_nettype none

package sasd_pkg;

  // Store geometry
  localparam int DEPTH    = 256;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 8;
  localparam int CAP_W    = 9;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LEN_W    = $clog2(DEPTH + 1);
  // common width for index and length compares
  localparam int CW       = (LEN_W > CAP_W) ? LEN_W : CAP_W;

  // Search window and scan grouping
  localparam int SRCH_N   = (DEPTH > 256) ? 256 : DEPTH;
  localparam int GRP      = 16;
  localparam int OFF_W    = $clog2(GRP);
  localparam int NGRP     = (SRCH_N + GRP - 1) / GRP;
  localparam int PAD_N    = NGRP * GRP;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2
  } op_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Command broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             srch;
    logic [VAL_W-1:0] value;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    len;
    logic [CW-1:0]    lim;
  } cell_cmd_t;

  // Scanner result
  typedef struct packed {
    logic             done;
    logic             found;
    logic [POS_W-1:0] index;
  } scan_res_t;

endpackage

`default_nettype wire

### hdl/sasd_in_if.sv
// ----------------------------------------------------------------------------
// sasd_in_if: request channel
// Valid/ready channel carrying one operation word: opcode, value, index.
// ----------------------------------------------------------------------------
`default_nettype none

interface sasd_in_if import sasd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        index;

  modport source (output valid, output opcode, output value, output index, input ready);
  modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

`default_nettype wire

### hdl/sasd_out_if.sv
// ----------------------------------------------------------------------------
// sasd_out_if: result channel
// Valid/ready channel carrying one result word: found, found_index, status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sasd_out_if import sasd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] found_index;
  logic             status;

  modport source (output valid, output found, output found_index, output status,
                  input ready);
  modport sink   (input valid, input found, input found_index, input status,
                  output ready);
endinterface

`default_nettype wire

### hdl/shift_array_insert_delete_search.sv
// ----------------------------------------------------------------------------
// shift_array_insert_delete_search: shift array with insert, delete, search
// A row of entry cells shifts up on insert and down on delete;
// search compares in every cell and scans the flags for the lowest match.
//
//   channel  dir  handshake          word
//   in_i     in   valid/ready        opcode, value, index
//   out_o    out  valid/ready        found, found_index, status
//   cfg      in   cfg_we_i           cfg_capacity_i (capacity)
//
// Insert, delete and other opcodes: result valid the next cycle. Search:
// compare at the accept edge, then scan groups of 16 cells up to the first
// match (16 groups for 256 cells); result registered once the slot is free.
// One word is in flight at a time; a held result stalls acceptance.
// Reset clears every cell to zero at once and sets capacity to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module shift_array_insert_delete_search import sasd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CAP_W-1:0] cfg_capacity_i,
  sasd_in_if.sink               in_i,
  sasd_out_if.source            out_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e           state_q, state_d;
  logic [CAP_W-1:0] cap_q;
  logic [CW-1:0]    len_c, lim_c, pos_c;
  logic             acc, oor, is_ins, is_del, is_srch, slot_free;
  cell_cmd_t        cmd;
  scan_res_t        scan_res;
  logic [VAL_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0] match;

  logic             out_valid_q, out_valid_d;
  logic             out_found_q, out_found_d;
  logic [POS_W-1:0] out_idx_q, out_idx_d;
  logic             out_status_q, out_status_d;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // Used length, search window and range check
  assign len_c = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign lim_c = (len_c > CW'(SRCH_N)) ? CW'(SRCH_N) : len_c;
  assign pos_c = CW'(in_i.index);
  assign oor   = (pos_c >= len_c);

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && slot_free;
  assign acc        = in_i.valid && in_i.ready;
  assign is_ins     = (in_i.opcode == OP_INSERT);
  assign is_del     = (in_i.opcode == OP_DELETE);
  assign is_srch    = (in_i.opcode == OP_SEARCH);

  // Broadcast command to the cells
  assign cmd.ins   = acc && is_ins && !oor;
  assign cmd.del   = acc && is_del && !oor;
  assign cmd.srch  = acc && is_srch;
  assign cmd.value = in_i.value;
  assign cmd.pos   = pos_c;
  assign cmd.len   = len_c;
  assign cmd.lim   = lim_c;

  // Row of cells, each wired to its neighbours
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = ent[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = ent[i+1];
    end
    sasd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(i)),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (ent[i]),
      .match_o (match[i])
    );
  end

  sasd_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.srch),
    .match_i (match[SRCH_N-1:0]),
    .res_o   (scan_res)
  );

  // Sequence: take a word, scan on search, hold a result until the slot frees
  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_found_d  = out_found_q;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (is_srch) begin
            state_d = ST_SCAN;
          end else begin
            out_valid_d  = 1'b1;
            out_found_d  = 1'b0;
            out_idx_d    = '0;
            out_status_d = ((is_ins || is_del) && oor) ? STATUS_RANGE : STATUS_OK;
          end
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (slot_free) begin
            state_d      = ST_IDLE;
            out_valid_d  = 1'b1;
            out_found_d  = scan_res.found;
            out_idx_d    = scan_res.index;
            out_status_d = STATUS_OK;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_found_d  = scan_res.found;
          out_idx_d    = scan_res.index;
          out_status_d = STATUS_OK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found       = out_found_q;
  assign out_o.found_index = out_idx_q;
  assign out_o.status      = out_status_q;

  // Out-of-range insert or delete reports a range error next cycle
  a_range_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (is_ins || is_del) && oor |=>
      out_valid_q && (out_status_q == STATUS_RANGE) && !out_found_q)
    else $error("range error not reported");

  // A match is only ever reported with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> (out_status_q == STATUS_OK))
    else $error("match reported with error status");

  // Scanner completes only while a search is in flight
  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_res.done |-> (state_q == ST_SCAN))
    else $error("scan completed outside a search");

endmodule

`default_nettype wire

### hdl/sasd_cell.sv
// ----------------------------------------------------------------------------
// sasd_cell: one entry of the shift array
// Holds one word, takes its lower or upper neighbour on insert or delete,
// and registers its compare result on search.
// ----------------------------------------------------------------------------
`default_nettype none

module sasd_cell import sasd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire logic [VAL_W-1:0] lower_i,
  input  wire logic [VAL_W-1:0] upper_i,
  output logic      [VAL_W-1:0] entry_o,
  output logic                  match_o
);

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             match_q, match_d;
  logic [CW-1:0]    idx_c;

  assign idx_c = CW'(idx_i);

  // Pick the next entry: load, take from below, take from above, or hold
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (idx_c == cmd_i.pos) begin
        entry_d = cmd_i.value;
      end else if ((idx_c > cmd_i.pos) && (idx_c < cmd_i.len)) begin
        entry_d = lower_i;
      end
    end else if (cmd_i.del) begin
      if ((idx_c >= cmd_i.pos) && ((idx_c + CW'(1)) < cmd_i.len)) begin
        entry_d = upper_i;
      end
    end
  end

  // Compare against the search word inside the window
  always_comb begin
    match_d = match_q;
    if (cmd_i.srch) begin
      match_d = (entry_q == cmd_i.value) && (idx_c < cmd_i.lim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      match_q <= 1'b0;
    end else begin
      entry_q <= entry_d;
      match_q <= match_d;
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

### hdl/sasd_scan.sv
// ----------------------------------------------------------------------------
// sasd_scan: lowest-match scanner
// Walks the registered match flags one group a cycle from the bottom and
// reports the first set flag, or no match after the last group.
// ----------------------------------------------------------------------------
`default_nettype none

module sasd_scan import sasd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SRCH_N-1:0] match_i,
  output scan_res_t              res_o
);

  localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NGRP - 1);

  logic [PAD_N-1:0] pad;
  logic [GRP-1:0]   grp_bits;
  logic             hit;
  logic [OFF_W-1:0] off_c;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic [POS_W-1:0] index_q, index_d;

  assign pad      = PAD_N'(match_i);
  assign grp_bits = pad[grp_q*GRP +: GRP];

  // Priority encode the current group, lowest bit wins
  always_comb begin
    hit   = 1'b0;
    off_c = '0;
    for (int b = GRP - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        hit   = 1'b1;
        off_c = OFF_W'(b);
      end
    end
  end

  // Advance one group a cycle, stop on a hit or after the last group
  always_comb begin
    grp_d   = grp_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    found_d = found_q;
    index_d = index_q;
    if (start_i) begin
      grp_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (hit || (grp_q == LAST_GRP)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        found_d = hit;
        index_d = hit ? POS_W'({grp_q, off_c}) : '0;
      end else begin
        grp_d = grp_q + GRP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      grp_q  <= grp_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    index_q <= index_d;
  end

  assign res_o.done  = done_q;
  assign res_o.found = found_q;
  assign res_o.index = index_q;

endmodule

`default_nettype wire

### verif/shift_array_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_array_checker: result predictor and comparator for the shift array
// Watches the request and result channels and the capacity write port, keeps
// its own copy of the store and the capacity, works out the result of every
// accepted request word and compares each accepted result word, field by
// field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module shift_array_checker import sasd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_capacity_i,
  sasd_in_if               in_w,
  sasd_out_if              out_w,
  output int               fail_cnt_o,
  output int               pending_cnt_o,
  output int               result_cnt_o,
  output int               hit_cnt_o,
  output int               range_cnt_o
);

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] found_index;
    logic             status;
  } result_t;

  logic [VAL_W-1:0] cells [DEPTH];
  logic [CAP_W-1:0] capacity;
  result_t          expected_q [$];

  // Apply one request word to the shadow store and return its result
  function automatic result_t apply_word(logic [1:0] op, logic [VAL_W-1:0] val,
                                         logic [POS_W-1:0] idx);
    result_t res;
    int      len;
    int      i;
    res = '0;
    len = (capacity > DEPTH) ? DEPTH : int'(capacity);
    if (op == OP_INSERT || op == OP_DELETE) begin
      if (int'(idx) >= len) begin
        res.status = STATUS_RANGE;
      end else if (op == OP_INSERT) begin
        // shift up from the top, dropping the last entry in use
        for (i = len - 1; i > int'(idx); i--) cells[IDX_W'(i)] = cells[IDX_W'(i - 1)];
        cells[idx] = val;
      end else begin
        // shift down, the last entry in use keeps its word
        for (i = int'(idx); i + 1 < len; i++) cells[IDX_W'(i)] = cells[IDX_W'(i + 1)];
      end
    end else if (op == OP_SEARCH) begin
      // lowest matching position within the search window
      for (i = 0; i < len && i < 256; i++) begin
        if (cells[IDX_W'(i)] == val) begin
          res.found       = 1'b1;
          res.found_index = POS_W'(i);
          break;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_r;
    if (!rst_ni) begin
      foreach (cells[k]) cells[k] = '0;
      capacity = CAP_RESET;
      expected_q.delete();
      fail_cnt_o    = 0;
      pending_cnt_o = 0;
      result_cnt_o  = 0;
      hit_cnt_o     = 0;
      range_cnt_o   = 0;
    end else begin
      // track capacity writes
      if (cfg_we_i) capacity = cfg_capacity_i;

      // predict the result of an accepted request word
      if (in_w.valid && in_w.ready) begin
        exp_r = apply_word(in_w.opcode, in_w.value, in_w.index);
        expected_q.push_back(exp_r);
      end

      // compare an accepted result word with the oldest prediction
      if (out_w.valid && out_w.ready) begin
        result_cnt_o++;
        if (expected_q.size() == 0) begin
          fail_cnt_o++;
          $display("%0t: result word with nothing expected (found=%0b index=%0d status=%0b)",
                   $time, out_w.found, out_w.found_index, out_w.status);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.found) hit_cnt_o++;
          if (exp_r.status == STATUS_RANGE) range_cnt_o++;
          if (out_w.found !== exp_r.found) begin
            fail_cnt_o++;
            $display("%0t: found mismatch: expected %0b, got %0b",
                     $time, exp_r.found, out_w.found);
          end
          if (out_w.found_index !== exp_r.found_index) begin
            fail_cnt_o++;
            $display("%0t: found_index mismatch: expected %0d, got %0d",
                     $time, exp_r.found_index, out_w.found_index);
          end
          if (out_w.status !== exp_r.status) begin
            fail_cnt_o++;
            $display("%0t: status mismatch: expected %0b, got %0b",
                     $time, exp_r.status, out_w.status);
          end
        end
      end
      pending_cnt_o = expected_q.size();
    end
  end

endmodule

### verif/shift_array_insert_delete_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shift_array_insert_delete_search_tb: testbench top for the shift array
// Drives a directed opening (field extremes, every opcode, out-of-range and
// zero-capacity cases) and then random request words over a series of
// capacity settings, with random gaps on the request side and random stalls
// on the result side. Checking is done by shift_array_checker.
// ----------------------------------------------------------------------------

module shift_array_insert_delete_search_tb;
  import sasd_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int         LIMIT    = 400000;
  localparam int         NPHASE   = 9;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_capacity_i;

  sasd_in_if  in_w ();
  sasd_out_if out_w ();

  int fail_cnt, pending_cnt, result_cnt, hit_cnt, range_cnt;
  int cycles;
  int words_sent;
  int cap_writes;
  bit gaps_on;

  logic [CAP_W-1:0] cap_now;
  logic [VAL_W-1:0] recent_vals [8];
  logic [CAP_W-1:0] phase_cap [NPHASE] = '{9'd256, 9'd16, 9'd1, 9'd511, 9'd255,
                                            9'd2, 9'd300, 9'd40, 9'd0};

  shift_array_insert_delete_search DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_capacity_i(cfg_capacity_i),
    .in_i          (in_w),
    .out_o         (out_w)
  );

  shift_array_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_capacity_i(cfg_capacity_i),
    .in_w          (in_w),
    .out_w         (out_w),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .result_cnt_o  (result_cnt),
    .hit_cnt_o     (hit_cnt),
    .range_cnt_o   (range_cnt)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Result side: stall at random while gaps are enabled
  initial begin
    int hold;
    hold = 0;
    out_w.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (gaps_on && hold == 0) hold = pick_gap();
      if (hold > 0) begin
        out_w.ready <= 1'b0;
        hold--;
      end else begin
        out_w.ready <= 1'b1;
      end
    end
  end

  // Send one request word; enters and leaves at a falling edge
  task automatic push_word(logic [1:0] op, logic [VAL_W-1:0] val, logic [POS_W-1:0] idx);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_w.valid  <= 1'b1;
    in_w.opcode <= op;
    in_w.value  <= val;
    in_w.index  <= idx;
    do @(posedge clk_i); while (!in_w.ready);
    words_sent++;
    if (op == OP_INSERT) recent_vals[3'($urandom_range(0, 7))] = val;
    @(negedge clk_i);
  endtask

  // Write capacity once every outstanding result has come back
  task automatic set_capacity(logic [CAP_W-1:0] cap);
    in_w.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
    cfg_we_i       <= 1'b1;
    cfg_capacity_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cap_now = cap;
    cap_writes++;
  endtask

  // One random request word, biased towards values already in the store
  task automatic push_random();
    int               len;
    int               r;
    logic [1:0]       op;
    logic [VAL_W-1:0] val;
    logic [POS_W-1:0] idx;
    len = (cap_now > DEPTH) ? DEPTH : int'(cap_now);
    r = $urandom_range(0, 19);
    if (r < 8)       op = OP_INSERT;
    else if (r < 13) op = OP_DELETE;
    else if (r < 19) op = OP_SEARCH;
    else             op = OP_SPARE;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: val = recent_vals[3'($urandom_range(0, 7))];
      4, 5:       val = $urandom_range(0, 3);
      6: begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end
      default:    val = $urandom;
    endcase
    r = $urandom_range(0, 7);
    if (len == 0 || r == 0) idx = POS_W'($urandom_range(0, 255));
    else if (r == 1)        idx = POS_W'(len - 1);
    else                    idx = POS_W'($urandom_range(0, len - 1));
    push_word(op, val, idx);
  endtask

  // Watchdog
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending_cnt);
    $display("Simulation FAILED");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int ph;
    int n;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_capacity_i <= CAP_RESET;
    in_w.valid     <= 1'b0;
    in_w.opcode    <= OP_INSERT;
    in_w.value     <= '0;
    in_w.index     <= '0;
    words_sent = 0;
    cap_writes = 0;
    gaps_on    = 1'b0;
    cap_now    = CAP_RESET;
    foreach (recent_vals[k]) recent_vals[k] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: cleared store, extremes of value and index, all opcodes
    push_word(OP_SEARCH, 32'h0000_0000, 8'd0);
    push_word(OP_SEARCH, 32'h0000_0001, 8'd0);
    push_word(OP_INSERT, 32'h7FFF_FFFF, 8'd0);
    push_word(OP_INSERT, 32'h8000_0000, 8'd255);
    push_word(OP_INSERT, 32'hFFFF_FFFF, 8'd128);
    push_word(OP_SEARCH, 32'h8000_0000, 8'd255);
    push_word(OP_SEARCH, 32'hFFFF_FFFF, 8'd0);
    push_word(OP_SPARE,  32'h7FFF_FFFF, 8'd255);
    push_word(OP_DELETE, 32'h0000_0000, 8'd255);
    push_word(OP_DELETE, 32'h0000_0000, 8'd0);
    push_word(OP_SEARCH, 32'h7FFF_FFFF, 8'd0);
    push_word(OP_SEARCH, 32'hFFFF_FFFF, 8'd0);

    // Directed: small capacity, out of range on both sides of the edge
    set_capacity(9'd4);
    push_word(OP_INSERT, 32'h0000_00AA, 8'd4);
    push_word(OP_DELETE, 32'h0000_0000, 8'd255);
    push_word(OP_INSERT, 32'h0000_00BB, 8'd3);
    push_word(OP_SEARCH, 32'h8000_0000, 8'd0);
    push_word(OP_DELETE, 32'h0000_0000, 8'd3);
    push_word(OP_SEARCH, 32'h0000_00BB, 8'd0);

    // Directed: zero capacity, nothing in range and no match
    set_capacity(9'd0);
    push_word(OP_INSERT, 32'h0000_0000, 8'd0);
    push_word(OP_DELETE, 32'h0000_0000, 8'd0);
    push_word(OP_SEARCH, 32'hFFFF_FFFF, 8'd0);

    // Random phases over several capacities; every third phase runs flat out
    for (ph = 0; ph < NPHASE; ph++) begin
      set_capacity(phase_cap[4'(ph)]);
      gaps_on = (ph % 3 != 2);
      for (n = 0; n < ((phase_cap[4'(ph)] == 0) ? 25 : 128); n++) push_random();
    end

    // Drain, then allow the block's latency to pass
    in_w.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d request words over %0d capacity settings, %0d results checked",
             words_sent, cap_writes, result_cnt);
    $display("Search hits: %0d, out-of-range rejects: %0d", hit_cnt, range_cnt);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
